// ----- rtl/hash_index_linear_probe_macros.svh -----
// assertion macros for the hash index checker
// no dependencies
`ifndef HASH_INDEX_LINEAR_PROBE_MACROS_SVH
`define HASH_INDEX_LINEAR_PROBE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define HIX_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// next-cycle implication
`define HIX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// ----- rtl/hix_pkg.sv -----
// shared types and constants for the hash index
// no dependencies
package hix_pkg;
	localparam int SLOT_COUNT = 1024;
	localparam logic [1:0] KIND_FIND   = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_ERASE  = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;
	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_FULL  = 2'd1;
	localparam logic [1:0] MARK_GRAVE = 2'd2;
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [31:0] NO_ID = 32'hffffffff;
	localparam int CNT_W = 11;
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] k0;
		logic [63:0] k1;
		logic [63:0] k2;
		logic [63:0] k3;
		logic [31:0] id;
		logic [63:0] mix;
	} req_t;
endpackage

// ----- rtl/hix_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module hix_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ----- rtl/hix_front.sv -----
// front end: accepts words and computes the 64-bit mix over pipelined multiplies
// depends on hix_pkg
module hix_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  hix_pkg::req_t   in_req,
	output logic            out_vld,
	output hix_pkg::req_t   out_req
);
	// low 64 bits of each 64x64 product, split into 32-bit partial products over two stages
	hix_pkg::req_t r_s1, r_s2, r_s3, r_s4, r_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [63:0] x_s1, x_s3;
	logic [63:0] pll_s2, plh_s2, phl_s2, pll_s4, plh_s4, phl_s4;
	logic [63:0] m1, m2, x3;

	always_comb begin
		m1 = pll_s2 + {plh_s2[31:0], 32'd0} + {phl_s2[31:0], 32'd0};
		m2 = pll_s4 + {plh_s4[31:0], 32'd0} + {phl_s4[31:0], 32'd0};
		x3 = m1 ^ (m1 >> 33);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= {in_vld, v_s1, v_s2, v_s3, v_s4};
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= in_req;
		x_s1 <= in_req.k0 ^ (in_req.k0 >> 33);
		r_s2 <= r_s1;
		pll_s2 <= x_s1[31:0] * hix_pkg::MIX_C1[31:0];
		plh_s2 <= x_s1[31:0] * hix_pkg::MIX_C1[63:32];
		phl_s2 <= x_s1[63:32] * hix_pkg::MIX_C1[31:0];
		r_s3 <= r_s2;
		x_s3 <= x3;
		r_s4 <= r_s3;
		pll_s4 <= x_s3[31:0] * hix_pkg::MIX_C2[31:0];
		plh_s4 <= x_s3[31:0] * hix_pkg::MIX_C2[63:32];
		phl_s4 <= x_s3[63:32] * hix_pkg::MIX_C2[31:0];
		r_s5 <= '{kind: r_s4.kind, k0: r_s4.k0, k1: r_s4.k1, k2: r_s4.k2, k3: r_s4.k3,
			id: r_s4.id, mix: m2 ^ (m2 >> 33)};
	end

	assign out_vld = v_s5;
	assign out_req = r_s5;
endmodule

// ----- rtl/hix_fifo.sv -----
// short queue between the front end and the probe engine
// depends on hix_pkg
module hix_fifo #(
	parameter int DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hix_pkg::req_t push_data,
	input  logic          pop,
	output logic          not_empty,
	output hix_pkg::req_t head,
	output logic [$clog2(DEPTH):0] fill
);
	localparam int AW = $clog2(DEPTH);
	hix_pkg::req_t store_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			fill_q <= fill_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_q] <= push_data;
	end

	assign not_empty = (fill_q != '0);
	assign head = store_q[rd_q];
	assign fill = fill_q;
endmodule

// ----- rtl/hix_engine.sv -----
// back end: clears marks after reset, then probes the table one slot at a time (READ, CHECK)
// depends on hix_pkg and hix_ram
module hix_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_vld,
	input  hix_pkg::req_t                req,
	output logic                         req_pop,
	output logic                         res_vld,
	output logic [1:0]                   res_status,
	output logic [31:0]                  res_id,
	output logic [hix_pkg::CNT_W-1:0]    res_live,
	output logic [hix_pkg::CNT_W-1:0]    res_grave
);
	localparam int AW = $clog2(hix_pkg::SLOT_COUNT);
	localparam int DW = 2 + 32 + 256;

	typedef enum logic [2:0] {CLEAR, IDLE, READ, CHECK, WRITE, REPLY} state_t;
	state_t state_q;
	hix_pkg::req_t cur_q;
	logic [AW-1:0] slot_q, grave_slot_q, addr;
	logic [AW:0] n_q;
	logic have_grave_q;
	logic [hix_pkg::CNT_W-1:0] live_q, grave_q;
	logic [1:0] status_q;
	logic [31:0] id_q;
	logic we, ready;
	logic [DW-1:0] wdata, rdata;
	logic [1:0] r_mark;
	logic [31:0] r_node;
	logic [255:0] r_key;
	logic [63:0] used10, lim;
	logic key_hit, find_hit, erase_hit, last_probe;

	assign {r_mark, r_node, r_key} = rdata;
	assign key_hit = (r_key == {cur_q.k3, cur_q.k2, cur_q.k1, cur_q.k0});
	assign find_hit = (r_mark == hix_pkg::MARK_FULL) && (cur_q.kind == hix_pkg::KIND_FIND) &&
		key_hit;
	assign erase_hit = (r_mark == hix_pkg::MARK_FULL) &&
		(cur_q.kind == hix_pkg::KIND_ERASE) && (r_node == cur_q.id);
	assign last_probe = (n_q == (AW+1)'(hix_pkg::SLOT_COUNT - 1));
	assign used10 = 64'(({1'b0, live_q} + {1'b0, grave_q} + 12'd1)) * 64'd10;
	assign lim = 64'(hix_pkg::SLOT_COUNT) * 64'd8;

	always_comb begin
		addr = slot_q;
		we = 1'b0;
		wdata = {hix_pkg::MARK_FULL, cur_q.id, cur_q.k3, cur_q.k2, cur_q.k1, cur_q.k0};
		unique case (state_q)
			CLEAR: begin
				we = 1'b1;
				wdata = {hix_pkg::MARK_EMPTY, 32'd0, 256'd0};
			end
			WRITE: begin
				we = 1'b1;
				if (cur_q.kind == hix_pkg::KIND_ERASE)
					wdata = {hix_pkg::MARK_GRAVE, r_node, r_key};
				else if (have_grave_q)
					addr = grave_slot_q;
			end
			default: ;
		endcase
	end

	hix_ram #(.WIDTH(DW), .DEPTH(hix_pkg::SLOT_COUNT)) u_table (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign ready = (state_q == IDLE);
	assign req_pop = ready && req_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			slot_q <= '0;
			n_q <= '0;
			have_grave_q <= 1'b0;
			grave_slot_q <= '0;
			live_q <= '0;
			grave_q <= '0;
			status_q <= hix_pkg::ST_NOT_FOUND;
			id_q <= hix_pkg::NO_ID;
			res_vld <= 1'b0;
			cur_q <= '0;
		end else begin
			res_vld <= (state_q == REPLY);
			unique case (state_q)
				CLEAR: begin
					slot_q <= slot_q + 1'b1;
					if (slot_q == AW'(hix_pkg::SLOT_COUNT - 1))
						state_q <= IDLE;
				end
				IDLE: begin
					if (req_vld) begin
						cur_q <= req;
						slot_q <= req.mix[AW-1:0];
						n_q <= '0;
						have_grave_q <= 1'b0;
						id_q <= hix_pkg::NO_ID;
						if (req.kind == hix_pkg::KIND_INSERT) begin
							status_q <= hix_pkg::ST_FULL;
							state_q <= (used10 < lim) ? READ : REPLY;
						end else begin
							status_q <= hix_pkg::ST_NOT_FOUND;
							if (req.kind == hix_pkg::KIND_FIND ||
								req.kind == hix_pkg::KIND_ERASE)
								state_q <= READ;
							else
								state_q <= REPLY;
						end
					end
				end
				READ: state_q <= CHECK;
				CHECK: begin
					n_q <= n_q + 1'b1;
					if (r_mark == hix_pkg::MARK_EMPTY) begin
						if (cur_q.kind == hix_pkg::KIND_INSERT)
							state_q <= WRITE;
						else
							state_q <= REPLY;
					end else if (find_hit) begin
						status_q <= hix_pkg::ST_DONE;
						id_q <= r_node;
						state_q <= REPLY;
					end else if (erase_hit) begin
						state_q <= WRITE;
					end else begin
						state_q <= last_probe ? REPLY : READ;
						slot_q <= (slot_q == AW'(hix_pkg::SLOT_COUNT - 1)) ? '0 :
							slot_q + 1'b1;
						if (cur_q.kind == hix_pkg::KIND_INSERT &&
							r_mark == hix_pkg::MARK_GRAVE && !have_grave_q) begin
							have_grave_q <= 1'b1;
							grave_slot_q <= slot_q;
						end
					end
				end
				WRITE: begin
					status_q <= hix_pkg::ST_DONE;
					state_q <= REPLY;
					if (cur_q.kind == hix_pkg::KIND_ERASE) begin
						live_q <= live_q - 1'b1;
						grave_q <= grave_q + 1'b1;
					end else begin
						live_q <= live_q + 1'b1;
						if (have_grave_q)
							grave_q <= grave_q - 1'b1;
					end
				end
				REPLY: begin
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign res_status = status_q;
	assign res_id = id_q;
	assign res_live = live_q;
	assign res_grave = grave_q;
endmodule

// ----- rtl/hash_index_linear_probe.sv -----
// Hash index with linear probing: a command channel (start/busy) in, a strobed result out.
// A word is taken at a rising edge with start high and busy low. The front end
// computes the 64-bit key mix in a pipeline of 32-bit partial products,
// then the word waits in an eight-entry queue for the probe engine.
// The engine reads one slot at a time (READ, CHECK) through a single-port table memory.
// Path of a word from the accepting edge, with an idle engine: the mix pipeline,
// pick-up from the queue, a READ and a CHECK per visited slot, a WRITE for each
// table write, then the REPLY state and the registered done strobe.
// The engine takes one word at a time; the next waits in the queue until it is idle.
// After reset the engine clears every slot mark, one slot a cycle.
// Words are still taken meanwhile and wait in the queue until the clear ends.
// Counts start at zero.
// Each result shows for one cycle with done high; the receiver cannot stall it.
// busy rises when the queue could overflow with words still in the front pipeline.
// depends on hix_pkg, hix_front, hix_fifo, hix_engine, hix_ram
module hash_index_linear_probe (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [63:0] key_word0,
	input  logic [63:0] key_word1,
	input  logic [63:0] key_word2,
	input  logic [63:0] key_word3,
	input  logic [31:0] node_id,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] found_id,
	output logic [10:0] entry_count,
	output logic [10:0] tombstone_count
);
	localparam int QD = 8;
	hix_pkg::req_t in_req, f_req, q_head;
	logic acc, f_vld, q_ne, pop;
	logic [$clog2(QD):0] fill;
	logic [2:0] inflight_q;

	assign in_req = '{kind: kind, k0: key_word0, k1: key_word1, k2: key_word2,
		k3: key_word3, id: node_id, mix: 64'd0};
	assign acc = start && !busy;
	// queue fill plus words in the front pipeline must stay below queue depth
	assign busy = (32'(fill) + 32'(inflight_q)) >= (QD - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + 3'(acc) - 3'(f_vld);
	end

	hix_front u_front (.clk(clk), .arst_n(arst_n), .in_vld(acc), .in_req(in_req),
		.out_vld(f_vld), .out_req(f_req));

	hix_fifo #(.DEPTH(QD)) u_fifo (.clk(clk), .arst_n(arst_n), .push(f_vld),
		.push_data(f_req), .pop(pop), .not_empty(q_ne), .head(q_head), .fill(fill));

	hix_engine u_engine (.clk(clk), .arst_n(arst_n),
		.req_vld(q_ne), .req(q_head), .req_pop(pop), .res_vld(done),
		.res_status(status), .res_id(found_id), .res_live(entry_count),
		.res_grave(tombstone_count));
endmodule

// ----- rtl/hix_checker.sv -----
// port-level checker for the hash index, bound to the top level
// depends on hix_pkg and hash_index_linear_probe_macros.svh
`include "hash_index_linear_probe_macros.svh"
module hix_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [31:0] found_id,
	input logic [10:0] entry_count,
	input logic [10:0] tombstone_count
);
	`HIX_ASSERT_IMP(a_status_code, done, status == hix_pkg::ST_DONE ||
		status == hix_pkg::ST_NOT_FOUND || status == hix_pkg::ST_FULL)
	`HIX_ASSERT_IMP(a_found_only_on_hit, done && status != hix_pkg::ST_DONE,
		found_id == hix_pkg::NO_ID)
	`HIX_ASSERT_NEXT(a_done_pulse, done, !done)
	// counts move only on the write just before a reply
	`HIX_ASSERT_NEXT(a_counts_before_done,
		!$stable(entry_count) || !$stable(tombstone_count), done)
	`HIX_ASSERT_IMP(a_busy_known, start, !$isunknown(busy))
endmodule
bind hash_index_linear_probe hix_checker u_hix_checker (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .done(done), .status(status), .found_id(found_id),
	.entry_count(entry_count), .tombstone_count(tombstone_count));

// ----- sim/hash_index_linear_probe_tb.sv -----
// self-checking testbench for hash_index_linear_probe: directed and random find/insert/erase
// depends on hix_pkg and the hash_index_linear_probe rtl
module hash_index_linear_probe_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = hix_pkg::SLOT_COUNT;
	localparam int STALL_LIMIT = 50000;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_id;
		logic [10:0] entry_count;
		logic [10:0] tombstone_count;
	} reply_t;

	typedef struct packed {
		logic [255:0] key;
		logic [31:0]  id;
	} entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = hix_pkg::KIND_FIND;
	logic [63:0] key_word0 = '0, key_word1 = '0, key_word2 = '0, key_word3 = '0;
	logic [31:0] node_id = '0;
	logic        done;
	logic [1:0]  status;
	logic [31:0] found_id;
	logic [10:0] entry_count, tombstone_count;

	// predictor state
	logic [1:0]   tab_mark [SLOTS];
	logic [31:0]  tab_id [SLOTS];
	logic [255:0] tab_key [SLOTS];
	int           live_n, grave_n;

	reply_t replies_due [$];
	entry_t stored [$];
	int     errors, words_sent, replies_seen, full_seen, watchdog;
	int     idle_pct;

	hash_index_linear_probe dut (.*);

	always #5 clk = ~clk;

	function automatic int home_of(logic [63:0] w);
		w ^= w >> 33;
		w = w * hix_pkg::MIX_C1;
		w ^= w >> 33;
		w = w * hix_pkg::MIX_C2;
		w ^= w >> 33;
		return int'(w % SLOTS);
	endfunction

	function automatic reply_t apply_request(logic [1:0] k, logic [255:0] key, logic [31:0] id);
		reply_t r;
		int s, grave;
		bit have_grave;
		s = home_of(key[63:0]);
		r.status = hix_pkg::ST_NOT_FOUND;
		r.found_id = hix_pkg::NO_ID;
		have_grave = 0;
		grave = 0;
		if (k == hix_pkg::KIND_FIND) begin
			for (int n = 0; n < SLOTS; n++) begin
				if (tab_mark[s] == hix_pkg::MARK_EMPTY) break;
				if (tab_mark[s] == hix_pkg::MARK_FULL && tab_key[s] == key) begin
					r.status = hix_pkg::ST_DONE;
					r.found_id = tab_id[s];
					break;
				end
				s = (s + 1) % SLOTS;
			end
		end else if (k == hix_pkg::KIND_INSERT) begin
			r.status = hix_pkg::ST_FULL;
			if ((live_n + grave_n + 1) * 10 < SLOTS * 8) begin
				for (int n = 0; n < SLOTS; n++) begin
					if (tab_mark[s] == hix_pkg::MARK_EMPTY) begin
						if (have_grave) begin
							s = grave;
							grave_n--;
						end
						tab_mark[s] = hix_pkg::MARK_FULL;
						tab_id[s] = id;
						tab_key[s] = key;
						live_n++;
						r.status = hix_pkg::ST_DONE;
						break;
					end
					if (tab_mark[s] == hix_pkg::MARK_GRAVE && !have_grave) begin
						have_grave = 1;
						grave = s;
					end
					s = (s + 1) % SLOTS;
				end
			end
		end else if (k == hix_pkg::KIND_ERASE) begin
			for (int n = 0; n < SLOTS; n++) begin
				if (tab_mark[s] == hix_pkg::MARK_EMPTY) break;
				if (tab_mark[s] == hix_pkg::MARK_FULL && tab_id[s] == id) begin
					tab_mark[s] = hix_pkg::MARK_GRAVE;
					live_n--;
					grave_n++;
					r.status = hix_pkg::ST_DONE;
					break;
				end
				s = (s + 1) % SLOTS;
			end
		end
		r.entry_count = 11'(live_n);
		r.tombstone_count = 11'(grave_n);
		return r;
	endfunction

	// drives one word at the falling edge and holds it until taken
	task automatic send_word(logic [1:0] k, logic [255:0] key, logic [31:0] id);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(6)) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		kind = k;
		{key_word3, key_word2, key_word1, key_word0} = key;
		node_id = id;
		do @(posedge clk); while (busy);
		replies_due = {replies_due, apply_request(k, key, id)};
		words_sent++;
		watchdog = 0;
		if (k == hix_pkg::KIND_INSERT) stored = {stored, entry_t'{key, id}};
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [255:0] rand_key();
		return {rand64(), rand64(), rand64(), rand64()};
	endfunction

	always @(posedge clk) begin
		watchdog++;
		if (watchdog > STALL_LIMIT) begin
			$display("hash_index_linear_probe_tb NOT OK");
			$finish;
		end
		if (arst_n && done) begin
			reply_t e;
			watchdog = 0;
			replies_seen++;
			if (replies_due.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = replies_due.pop_front();
				if (e.status == hix_pkg::ST_FULL) full_seen++;
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					errors++;
				end
				if (found_id !== e.found_id) begin
					$error("found_id: expected %h, got %h", e.found_id, found_id);
					errors++;
				end
				if (entry_count !== e.entry_count) begin
					$error("entry_count: expected %0d, got %0d", e.entry_count, entry_count);
					errors++;
				end
				if (tombstone_count !== e.tombstone_count) begin
					$error("tombstone_count: expected %0d, got %0d", e.tombstone_count,
						tombstone_count);
					errors++;
				end
			end
		end
	end

	task automatic test_empty_table();
		send_word(hix_pkg::KIND_FIND, '0, '0);
		send_word(hix_pkg::KIND_ERASE, {256{1'b1}}, 32'hffff_fffe);
		send_word(hix_pkg::KIND_NONE, rand_key(), $urandom);
	endtask

	task automatic test_extremes();
		send_word(hix_pkg::KIND_INSERT, '0, '0);
		send_word(hix_pkg::KIND_INSERT, {256{1'b1}}, 32'hffff_fffe);
		send_word(hix_pkg::KIND_FIND, '0, 32'hffff_fffe);
		send_word(hix_pkg::KIND_FIND, {256{1'b1}}, '0);
		send_word(hix_pkg::KIND_ERASE, '0, 32'hffff_fffe);
		send_word(hix_pkg::KIND_FIND, {256{1'b1}}, '0);
	endtask

	// same first word, so same home slot: probe chains, tombstone skip and reuse, duplicates
	task automatic test_collisions();
		logic [63:0] w;
		w = rand64();
		send_word(hix_pkg::KIND_INSERT, {192'd1, w}, 32'd100);
		send_word(hix_pkg::KIND_INSERT, {192'd2, w}, 32'd101);
		send_word(hix_pkg::KIND_INSERT, {192'd2, w}, 32'd102);
		send_word(hix_pkg::KIND_FIND, {192'd2, w}, '0);
		send_word(hix_pkg::KIND_ERASE, {192'd9, w}, 32'd100);
		send_word(hix_pkg::KIND_FIND, {192'd2, w}, '0);
		send_word(hix_pkg::KIND_FIND, {192'd1, w}, '0);
		send_word(hix_pkg::KIND_INSERT, {192'd3, w}, 32'd103);
		send_word(hix_pkg::KIND_FIND, {192'd3, w}, '0);
		send_word(hix_pkg::KIND_ERASE, {192'd0, w}, 32'd999);
	endtask

	// chain starting at the last slot wraps to slot 0
	task automatic test_wrap();
		logic [63:0] w;
		do w = rand64(); while (home_of(w) != SLOTS - 1);
		for (int i = 0; i < 3; i++)
			send_word(hix_pkg::KIND_INSERT, {192'(i), w}, 32'(200 + i));
		send_word(hix_pkg::KIND_FIND, {192'd2, w}, '0);
		send_word(hix_pkg::KIND_ERASE, {192'd0, w}, 32'd202);
	endtask

	task automatic test_random(int n, int idle, int insert_pct);
		entry_t e;
		logic [255:0] key;
		int r;
		idle_pct = idle;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (stored.size() != 0) e = stored[$urandom_range(stored.size() - 1)];
			if (r < insert_pct) begin
				key = rand_key();
				if (stored.size() != 0 && $urandom_range(3) == 0) key[63:0] = e.key[63:0];
				send_word(hix_pkg::KIND_INSERT, key,
					($urandom_range(3) == 0) ? 32'($urandom_range(63)) : $urandom);
			end else if (r < insert_pct + 25 && stored.size() != 0) begin
				send_word(hix_pkg::KIND_FIND, e.key, $urandom);
			end else if (r < insert_pct + 40 && stored.size() != 0) begin
				send_word(hix_pkg::KIND_ERASE, rand_key(), e.id);
			end else if (r < 97) begin
				send_word($urandom_range(1) ? hix_pkg::KIND_FIND : hix_pkg::KIND_ERASE,
					rand_key(), $urandom);
			end else begin
				send_word(hix_pkg::KIND_NONE, rand_key(), $urandom);
			end
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) tab_mark[i] = hix_pkg::MARK_EMPTY;
		live_n = 0;
		grave_n = 0;
		errors = 0;
		idle_pct = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_table();
		test_extremes();
		test_collisions();
		test_wrap();
		drain();
		test_random(350, 15, 45);
		test_random(250, 82, 45);
		test_random(500, 0, 70);
		repeat (50) @(posedge clk);
		$display("sent %0d words, checked %0d results, %0d refused as full",
			words_sent, replies_seen, full_seen);
		$display("final load: %0d live, %0d tombstones", live_n, grave_n);
		if (errors == 0 && replies_due.size() == 0) begin
			$display("hash_index_linear_probe_tb OK");
		end else begin
			$display("hash_index_linear_probe_tb NOT OK");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/hix_pkg.sv
rtl/hix_ram.sv
rtl/hix_front.sv
rtl/hix_fifo.sv
rtl/hix_engine.sv
rtl/hash_index_linear_probe.sv
rtl/hix_checker.sv
sim/hash_index_linear_probe_tb.sv
